// File: rtl/ffba_pkg.sv
// Package for the block allocator: sizes, codes and the word types of its channels.
// Depends on nothing; the allocator top level uses it by scoped names.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int NumBlocks = 8;
  localparam int SizeW     = 16;
  localparam int IdxW      = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int CfgW      = 4;
  localparam int FragW     = 19;
  localparam int AmountW   = 16;
  localparam int PidW      = 4;
  localparam int BlkW      = 3;
  // Width that holds an entry number, a block index and the active count alike.
  localparam int CmpW      = ((IdxW > CfgW) ? IdxW : CfgW) + 1;
  localparam logic [CfgW-1:0] ActiveReset = CfgW'(8);

  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_REQUEST = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_LOADED = 2'd0,
    STATUS_ALLOC  = 2'd1,
    STATUS_NOFIT  = 2'd2
  } status_e;

  typedef struct packed {
    func_e               func;
    logic [BlkW-1:0]     block_index;
    logic [AmountW-1:0]  amount;
    logic [PidW-1:0]     process_id;
  } in_word_t;

  typedef struct packed {
    status_e             status;
    logic [BlkW-1:0]     chosen_block;
    logic [FragW-1:0]    fragmentation;
  } out_word_t;

  // One table entry as it sits in the block memory.
  typedef struct packed {
    logic [SizeW-1:0]    remaining;
    logic                taken;
    logic [PidW-1:0]     owner;
  } entry_t;

endpackage

// File: rtl/first_fit_block_allocator_top.sv
// Top level of the block allocator: block table memory, scan sequencer and output register.
// Depends on ffba_pkg for sizes, codes and the channel word types.
`timescale 1ns / 1ps

// The block keeps a table of memory blocks, each with a remaining size, a
// taken mark and an owner. An input word either loads one block's size (and
// frees it) or requests space for a process; a request takes the first free
// active block, in index order, whose remaining size covers it. Every input
// word gives one output word: a status, the chosen block and the fragmentation.
//
// Both data channels use valid and ready. The configuration channel is always ready and
// carries the active block count, which the user must write only while idle (not enforced).
//
// The table lives in a single memory with one read and one write port and a
// registered read. Each input word walks the whole table once, one entry per
// cycle, reading and updating each entry and writing back those it changes.
// The output word is registered once the walk is done and the output
// register is free, and the block takes no new input word until then.
//
// After reset every entry reads as zero size, free and unowned, through
// per-entry valid bits, and the active count is eight. A finished output word
// waits in the output register while the receiver stalls, and the next result
// waits in the sequencer until that register frees.

module first_fit_block_allocator_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ffba_pkg::in_word_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ffba_pkg::out_word_t   out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [ffba_pkg::CfgW-1:0] cfg_data_i
);

  // Sequencer states: waiting for a word, walking the table, handing off the result.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [ffba_pkg::CfgW-1:0]  active_q;
  ffba_pkg::in_word_t         item_q;
  logic [ffba_pkg::IdxW-1:0]  cnt_q, cnt_d;
  logic [ffba_pkg::FragW-1:0] acc_q, acc_d;
  logic                       found_q, found_d;
  logic [ffba_pkg::BlkW-1:0]  chosen_q, chosen_d;

  // Table memory with valid bits that make unwritten entries read as zero.
  ffba_pkg::entry_t           mem_q [ffba_pkg::NumBlocks];
  logic [ffba_pkg::NumBlocks-1:0] vld_q;
  ffba_pkg::entry_t           rd_q;
  logic                       rd_vld_q;
  logic [ffba_pkg::IdxW-1:0]  rd_addr;
  logic                       wr_en;
  ffba_pkg::entry_t           wr_data;

  logic                       out_valid_q;
  ffba_pkg::out_word_t        out_q;
  logic                       out_free;
  logic                       in_accept;

  // Per-entry update terms.
  ffba_pkg::entry_t           ent;
  logic [ffba_pkg::SizeW-1:0] amt;
  logic                       is_load;
  logic                       active;
  logic                       load_hit;
  logic                       fit;
  logic                       last;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ent      = rd_vld_q ? rd_q : '0;
  assign amt      = ffba_pkg::SizeW'(item_q.amount);
  assign is_load  = (item_q.func == ffba_pkg::FUNC_LOAD);
  assign active   = (ffba_pkg::CmpW'(cnt_q) < ffba_pkg::CmpW'(active_q));
  assign load_hit = is_load && (ffba_pkg::CmpW'(item_q.block_index) == ffba_pkg::CmpW'(cnt_q));
  assign fit      = !is_load && active && !found_q && !ent.taken && (ent.remaining >= amt);
  assign last     = (cnt_q == ffba_pkg::IdxW'(ffba_pkg::NumBlocks - 1));

  always_comb begin
    wr_data = ent;
    if (load_hit) begin
      wr_data.remaining = amt;
      wr_data.taken     = 1'b0;
      wr_data.owner     = '0;
    end else if (fit) begin
      wr_data.remaining = ent.remaining - amt;
      wr_data.taken     = 1'b1;
      wr_data.owner     = item_q.process_id;
    end
  end

  assign wr_en   = (state_q == S_SCAN) && (load_hit || fit);
  assign rd_addr = (state_q == S_IDLE) ? '0 : cnt_q + 1'b1;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    found_d  = found_q;
    chosen_d = chosen_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d  = S_SCAN;
          cnt_d    = '0;
          acc_d    = '0;
          found_d  = 1'b0;
          chosen_d = '0;
        end
      end
      S_SCAN: begin
        // The sum takes the entry's value after this word's update.
        if (active) begin
          acc_d = acc_q + ffba_pkg::FragW'(wr_data.remaining);
        end
        if (fit) begin
          found_d  = 1'b1;
          chosen_d = ffba_pkg::BlkW'(cnt_q);
        end
        if (last) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= ffba_pkg::ActiveReset;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= cfg_data_i;
      end
      if (wr_en) begin
        vld_q[cnt_q] <= 1'b1;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and the memory need no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    acc_q    <= acc_d;
    chosen_q <= chosen_d;
    if (wr_en) begin
      mem_q[cnt_q] <= wr_data;
    end
    rd_q     <= mem_q[rd_addr];
    rd_vld_q <= vld_q[rd_addr];
    if (state_q == S_DONE && out_free) begin
      out_q.chosen_block  <= chosen_q;
      out_q.fragmentation <= acc_q;
      if (is_load) begin
        out_q.status <= ffba_pkg::STATUS_LOADED;
      end else if (found_q) begin
        out_q.status <= ffba_pkg::STATUS_ALLOC;
      end else begin
        out_q.status <= ffba_pkg::STATUS_NOFIT;
      end
    end
  end

endmodule
